>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a boolean expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks a sequence property at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> rtl/core/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Delta timer queue package
// Sizes, operation codes and result kinds shared by the timer queue files.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int DEPTH   = 32;
  localparam int ID_BITS = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int OP_W    = 2;
  localparam int TID_W   = 16;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 3;
  localparam int OCC_W   = 6;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ZERO_TIME = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd5;

endpackage

>>> rtl/core/dtq_in_if.sv
// ----------------------------------------------------------------------------
// Timer queue request channel
// Valid/ready channel carrying one queue operation per transaction.
// ----------------------------------------------------------------------------
interface dtq_in_if;
  logic                        valid;
  logic                        ready;
  logic [dtq_pkg::OP_W-1:0]    operation;
  logic [dtq_pkg::TID_W-1:0]   thread_id;
  logic [dtq_pkg::TIME_W-1:0]  wait_time;

  modport source (output valid, output operation, output thread_id, output wait_time,
                  input ready);
  modport sink (input valid, input operation, input thread_id, input wait_time,
                output ready);
  modport monitor (input valid, input ready, input operation, input thread_id,
                   input wait_time);
endinterface

>>> rtl/core/dtq_out_if.sv
// ----------------------------------------------------------------------------
// Timer queue result channel
// Valid/ready channel carrying one queue result per transaction.
// ----------------------------------------------------------------------------
interface dtq_out_if;
  logic                        valid;
  logic                        ready;
  logic [dtq_pkg::KIND_W-1:0]  kind;
  logic [dtq_pkg::TID_W-1:0]   thread_id_res;
  logic                        last;
  logic [dtq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, output kind, output thread_id_res, output last,
                  output occupancy, input ready);
  modport sink (input valid, input kind, input thread_id_res, input last,
                input occupancy, output ready);
  modport monitor (input valid, input ready, input kind, input thread_id_res,
                   input last, input occupancy);
endinterface

>>> rtl/core/delta_timer_queue.sv
// ----------------------------------------------------------------------------
// Delta timer queue
// Delta-list sleep queue, walked one entry per cycle unless rsp stalls it.
// ----------------------------------------------------------------------------
// Requests arrive on req (insert, tick or cancel) and results leave on rsp.
// Every request except the unused operation code yields one or more results,
// and the final result of a request has last set.
// One request is handled at a time: req.ready is high only while the
// sequencer is idle, so a request is not taken until the previous one is done.
// An insert walks past each entry whose delta is below its remaining time,
// subtracting that delta, and is rejected when the time is zero or the queue
// is full; a cancel compares entries in turn until the id matches, then
// deletes that entry and adds its delta to the next one; a tick decrements
// the head delta and, once it is zero, releases the leading entries whose
// delta is zero, one per step. The insert walk, the tick decrement and the
// cancel fix-up share the single 32-bit add/subtract unit.
// Results go through an output register; the sequencer holds in a step that
// produces a result while that register is full and rsp.ready is low, so a
// stalled receiver freezes the sequence without loss.
// Synchronous reset empties the queue and the output register; entry
// contents are not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module delta_timer_queue (
  input  logic      clk,
  input  logic      rst,
  dtq_in_if.sink    req,
  dtq_out_if.source rsp
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_INS_WALK = 3'd2;
  localparam logic [2:0] S_INS_PUT  = 3'd3;
  localparam logic [2:0] S_CAN_WALK = 3'd4;
  localparam logic [2:0] S_CAN_DEL  = 3'd5;
  localparam logic [2:0] S_CAN_FIX  = 3'd6;
  localparam logic [2:0] S_TICK     = 3'd7;

  logic [2:0]                       state, state_next;
  logic                             releasing, releasing_next;
  logic [dtq_pkg::CNT_W-1:0]        pos, pos_next;
  logic [dtq_pkg::CNT_W-1:0]        count, count_next;
  logic [dtq_pkg::TIME_W-1:0]       t_rem, t_rem_next;
  logic [dtq_pkg::OP_W-1:0]         cur_op;
  logic [dtq_pkg::ID_BITS-1:0]      cur_id;

  logic [dtq_pkg::ID_BITS-1:0]      ent_id    [dtq_pkg::DEPTH];
  logic [dtq_pkg::TIME_W-1:0]       ent_delta [dtq_pkg::DEPTH];

  logic                             out_valid;
  logic [dtq_pkg::KIND_W-1:0]       out_kind;
  logic [dtq_pkg::TID_W-1:0]        out_id;
  logic                             out_last;
  logic [dtq_pkg::OCC_W-1:0]        out_occ;
  logic                             out_free;

  logic                             emit;
  logic [dtq_pkg::KIND_W-1:0]       emit_kind;
  logic [dtq_pkg::TID_W-1:0]        emit_id;
  logic                             emit_last;
  logic [dtq_pkg::CNT_W-1:0]        emit_occ;
  logic                             step;

  logic [dtq_pkg::ID_BITS-1:0]      rd_id;
  logic [dtq_pkg::TIME_W-1:0]       rd_delta;
  logic [dtq_pkg::TIME_W-1:0]       unit_a, unit_b;
  logic                             unit_sub;
  logic [dtq_pkg::TIME_W:0]         unit_full;
  logic [dtq_pkg::TIME_W-1:0]       unit_res;
  logic                             walk_gt;
  logic                             rel_last;

  assign out_free = !out_valid || rsp.ready;
  assign rd_id    = ent_id[pos[dtq_pkg::IDX_W-1:0]];
  assign rd_delta = ent_delta[pos[dtq_pkg::IDX_W-1:0]];

  // Shared add/subtract unit.
  always_comb begin
    unit_a   = rd_delta;
    unit_b   = t_rem;
    unit_sub = 1'b1;
    case (state)
      S_INS_WALK: begin
        unit_a = t_rem;
        unit_b = rd_delta;
      end
      S_CAN_FIX: begin
        unit_sub = 1'b0;
      end
      S_TICK: begin
        unit_a = ent_delta[0];
        unit_b = dtq_pkg::TIME_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign unit_full = unit_sub ? ({1'b0, unit_a} - {1'b0, unit_b})
                              : ({1'b0, unit_a} + {1'b0, unit_b});
  assign unit_res  = unit_full[dtq_pkg::TIME_W-1:0];
  assign walk_gt   = !unit_full[dtq_pkg::TIME_W] && (unit_res != '0);
  assign rel_last  = (count == dtq_pkg::CNT_W'(1)) || (ent_delta[1] != '0);

  always_comb begin
    state_next     = state;
    releasing_next = releasing;
    pos_next       = pos;
    count_next     = count;
    t_rem_next     = t_rem;
    emit           = 1'b0;
    emit_kind      = dtq_pkg::KIND_ACCEPTED;
    emit_id        = dtq_pkg::TID_W'(cur_id);
    emit_last      = 1'b1;
    emit_occ       = count;
    step           = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        pos_next = '0;
        case (cur_op)
          dtq_pkg::OP_INSERT: begin
            if (t_rem == '0) begin
              emit      = out_free;
              emit_kind = dtq_pkg::KIND_ZERO_TIME;
              if (out_free) state_next = S_IDLE;
            end else if (count >= dtq_pkg::CNT_W'(dtq_pkg::DEPTH)) begin
              emit      = out_free;
              emit_kind = dtq_pkg::KIND_FULL;
              if (out_free) state_next = S_IDLE;
            end else begin
              state_next = S_INS_WALK;
            end
          end
          dtq_pkg::OP_TICK: begin
            releasing_next = 1'b0;
            if (count == '0) begin
              emit      = out_free;
              emit_kind = dtq_pkg::KIND_NONE;
              emit_id   = '0;
              if (out_free) state_next = S_IDLE;
            end else begin
              state_next = S_TICK;
            end
          end
          dtq_pkg::OP_CANCEL: begin
            state_next = S_CAN_WALK;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_INS_WALK: begin
        if (pos != count && walk_gt) begin
          t_rem_next = unit_res;
          pos_next   = pos + dtq_pkg::CNT_W'(1);
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        if (out_free) begin
          step       = 1'b1;
          count_next = count + dtq_pkg::CNT_W'(1);
          emit       = 1'b1;
          emit_occ   = count + dtq_pkg::CNT_W'(1);
          state_next = S_IDLE;
        end
      end
      S_CAN_WALK: begin
        if (pos == count) begin
          emit      = out_free;
          emit_kind = dtq_pkg::KIND_NOT_FOUND;
          if (out_free) state_next = S_IDLE;
        end else if (rd_id == cur_id) begin
          t_rem_next = rd_delta;
          state_next = S_CAN_DEL;
        end else begin
          pos_next = pos + dtq_pkg::CNT_W'(1);
        end
      end
      S_CAN_DEL: begin
        if (out_free) begin
          step       = 1'b1;
          count_next = count - dtq_pkg::CNT_W'(1);
          emit       = 1'b1;
          emit_occ   = count - dtq_pkg::CNT_W'(1);
          state_next = S_CAN_FIX;
        end
      end
      S_CAN_FIX: begin
        step       = 1'b1;
        state_next = S_IDLE;
      end
      S_TICK: begin
        if (out_free) begin
          step = 1'b1;
          if (!releasing) begin
            if (unit_res != '0) begin
              emit      = 1'b1;
              emit_kind = dtq_pkg::KIND_NONE;
              emit_id   = '0;
              state_next = S_IDLE;
            end else begin
              releasing_next = 1'b1;
            end
          end else begin
            emit       = 1'b1;
            emit_kind  = dtq_pkg::KIND_RELEASED;
            emit_id    = dtq_pkg::TID_W'(ent_id[0]);
            emit_last  = rel_last;
            emit_occ   = count - dtq_pkg::CNT_W'(1);
            count_next = count - dtq_pkg::CNT_W'(1);
            if (rel_last) state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      releasing <= 1'b0;
      count     <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      releasing <= releasing_next;
      count     <= count_next;
      pos       <= pos_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cur_op <= req.operation;
      cur_id <= req.thread_id[dtq_pkg::ID_BITS-1:0];
      t_rem  <= req.wait_time;
    end else begin
      t_rem  <= t_rem_next;
    end
    if (emit) begin
      out_kind <= emit_kind;
      out_id   <= emit_id;
      out_last <= emit_last;
      out_occ  <= dtq_pkg::OCC_W'(emit_occ);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      case (state)
        S_INS_PUT: begin
          for (int i = 1; i < dtq_pkg::DEPTH; i++) begin
            if (dtq_pkg::CNT_W'(i) > pos) begin
              ent_id[i] <= ent_id[i-1];
              if (dtq_pkg::CNT_W'(i) == pos + dtq_pkg::CNT_W'(1)) begin
                ent_delta[i] <= unit_res;
              end else begin
                ent_delta[i] <= ent_delta[i-1];
              end
            end
          end
          ent_id[pos[dtq_pkg::IDX_W-1:0]]    <= cur_id;
          ent_delta[pos[dtq_pkg::IDX_W-1:0]] <= t_rem;
        end
        S_CAN_DEL: begin
          for (int i = 0; i < dtq_pkg::DEPTH - 1; i++) begin
            if (dtq_pkg::CNT_W'(i) >= pos) begin
              ent_id[i]    <= ent_id[i+1];
              ent_delta[i] <= ent_delta[i+1];
            end
          end
        end
        S_CAN_FIX: begin
          if (pos < count) begin
            ent_delta[pos[dtq_pkg::IDX_W-1:0]] <= unit_res;
          end
        end
        S_TICK: begin
          if (!releasing) begin
            ent_delta[0] <= unit_res;
          end else begin
            for (int i = 0; i < dtq_pkg::DEPTH - 1; i++) begin
              ent_id[i]    <= ent_id[i+1];
              ent_delta[i] <= ent_delta[i+1];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.kind          = out_kind;
  assign rsp.thread_id_res = out_id;
  assign rsp.last          = out_last;
  assign rsp.occupancy     = out_occ;

endmodule

>>> rtl/core/dtq_checker.sv
// ----------------------------------------------------------------------------
// Delta timer queue checker
// Port-level assertions on the timer queue channels, bound into the queue module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtq_checker (
  input logic       clk,
  input logic       rst,
  dtq_in_if.sink    req,
  dtq_out_if.source rsp
);

  `ASSERT_PROP(a_busy_after_accept, clk, rst, ((req.valid && req.ready) |=> !req.ready), "request accepted while busy")
  `ASSERT_ALWAYS(a_occ_bound, clk, rst, (!rsp.valid || rsp.occupancy <= dtq_pkg::OCC_W'(dtq_pkg::DEPTH)), "occupancy above depth")
  `ASSERT_ALWAYS(a_single_last, clk, rst, (!rsp.valid || rsp.kind == dtq_pkg::KIND_RELEASED || rsp.last), "single result without last")
  `ASSERT_ALWAYS(a_none_id, clk, rst, (!rsp.valid || rsp.kind != dtq_pkg::KIND_NONE || rsp.thread_id_res == '0), "empty tick result carries an id")
  `ASSERT_PROP(a_rsp_hold, clk, rst, ((rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.kind) && $stable(rsp.thread_id_res))), "stalled result changed")

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Delta timer queue testbench
// Drives insert, tick and cancel requests into the sleep queue and keeps its
// own copy of the delta list. Each request's results are predicted when the
// request is accepted, and every result is compared with them in order.
// Random stalls on both channels, one long receiver hold at the start of the
// table-filling test and a watchdog on stalled traffic complete the checks.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [dtq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [dtq_pkg::KIND_W-1:0] kind;
    logic [dtq_pkg::TID_W-1:0]  tid;
    logic                       last;
    logic [dtq_pkg::OCC_W-1:0]  occ;
  } result_t;

  logic clk;
  logic rst;

  dtq_in_if  req ();
  dtq_out_if rsp ();

  delta_timer_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic [dtq_pkg::TID_W-1:0]  sleeper_id    [dtq_pkg::DEPTH];
  logic [dtq_pkg::TIME_W-1:0] sleeper_delta [dtq_pkg::DEPTH];
  int                         sleeper_count;
  result_t                    expected_results [$];
  int                         error_count;
  bit                         steady_flow;
  int                         rsp_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [dtq_pkg::IDX_W-1:0] slot(input int k);
    return dtq_pkg::IDX_W'(k);
  endfunction

  function automatic logic [dtq_pkg::TID_W-1:0] any_tid();
    return dtq_pkg::TID_W'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic void expect_result(input logic [dtq_pkg::KIND_W-1:0] kind,
                                        input logic [dtq_pkg::TID_W-1:0] tid,
                                        input logic last, input int occ);
    result_t item;
    item.kind = kind;
    item.tid  = tid;
    item.last = last;
    item.occ  = occ[dtq_pkg::OCC_W-1:0];
    expected_results.push_back(item);
  endfunction

  function automatic void advance_sleep_queue(input logic [dtq_pkg::OP_W-1:0] op,
                                              input logic [dtq_pkg::TID_W-1:0] tid,
                                              input logic [dtq_pkg::TIME_W-1:0] wait_ticks);
    logic [dtq_pkg::TIME_W-1:0] rem;
    int pos;
    int n;
    int i;
    rem = wait_ticks;
    case (op)
      dtq_pkg::OP_INSERT: begin
        if (rem == '0) begin
          expect_result(dtq_pkg::KIND_ZERO_TIME, tid, 1'b1, sleeper_count);
        end else if (sleeper_count >= dtq_pkg::DEPTH) begin
          expect_result(dtq_pkg::KIND_FULL, tid, 1'b1, sleeper_count);
        end else begin
          pos = 0;
          while (pos < sleeper_count && rem > sleeper_delta[slot(pos)]) begin
            rem = rem - sleeper_delta[slot(pos)];
            pos++;
          end
          for (i = sleeper_count; i > pos; i--) begin
            sleeper_id[slot(i)]    = sleeper_id[slot(i - 1)];
            sleeper_delta[slot(i)] = sleeper_delta[slot(i - 1)];
          end
          sleeper_id[slot(pos)]    = tid;
          sleeper_delta[slot(pos)] = rem;
          sleeper_count++;
          if (pos + 1 < sleeper_count) begin
            sleeper_delta[slot(pos + 1)] = sleeper_delta[slot(pos + 1)] - rem;
          end
          expect_result(dtq_pkg::KIND_ACCEPTED, tid, 1'b1, sleeper_count);
        end
      end
      dtq_pkg::OP_TICK: begin
        if (sleeper_count == 0) begin
          expect_result(dtq_pkg::KIND_NONE, '0, 1'b1, 0);
        end else begin
          sleeper_delta[0] = sleeper_delta[0] - dtq_pkg::TIME_W'(1);
          if (sleeper_delta[0] != '0) begin
            expect_result(dtq_pkg::KIND_NONE, '0, 1'b1, sleeper_count);
          end else begin
            n = 0;
            while (n < sleeper_count && sleeper_delta[slot(n)] == '0) begin
              n++;
            end
            for (i = 0; i < n; i++) begin
              expect_result(dtq_pkg::KIND_RELEASED, sleeper_id[slot(i)], (i == n - 1),
                            sleeper_count - (i + 1));
            end
            for (i = n; i < sleeper_count; i++) begin
              sleeper_id[slot(i - n)]    = sleeper_id[slot(i)];
              sleeper_delta[slot(i - n)] = sleeper_delta[slot(i)];
            end
            sleeper_count -= n;
          end
        end
      end
      dtq_pkg::OP_CANCEL: begin
        pos = 0;
        while (pos < sleeper_count && sleeper_id[slot(pos)] != tid) begin
          pos++;
        end
        if (pos >= sleeper_count) begin
          expect_result(dtq_pkg::KIND_NOT_FOUND, tid, 1'b1, sleeper_count);
        end else begin
          if (pos + 1 < sleeper_count) begin
            sleeper_delta[slot(pos + 1)] = sleeper_delta[slot(pos + 1)]
                                           + sleeper_delta[slot(pos)];
          end
          for (i = pos + 1; i < sleeper_count; i++) begin
            sleeper_id[slot(i - 1)]    = sleeper_id[slot(i)];
            sleeper_delta[slot(i - 1)] = sleeper_delta[slot(i)];
          end
          sleeper_count--;
          expect_result(dtq_pkg::KIND_ACCEPTED, tid, 1'b1, sleeper_count);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic issue_request(input logic [dtq_pkg::OP_W-1:0] op,
                               input logic [dtq_pkg::TID_W-1:0] tid,
                               input logic [dtq_pkg::TIME_W-1:0] wait_ticks);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.operation = op;
    req.thread_id = tid;
    req.wait_time = wait_ticks;
    req.valid     = 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    advance_sleep_queue(op, tid, wait_ticks);
  endtask

  task automatic test_list_edges();
    issue_request(dtq_pkg::OP_TICK, 16'h0000, 32'h0000_0000);
    issue_request(dtq_pkg::OP_INSERT, 16'hFFFF, 32'h0000_0000);
    issue_request(dtq_pkg::OP_INSERT, 16'h0000, 32'h0000_0001);
    issue_request(dtq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    issue_request(dtq_pkg::OP_INSERT, 16'h1234, 32'h0000_0001);
    issue_request(dtq_pkg::OP_TICK, 16'h0000, 32'h0000_0000);
    issue_request(dtq_pkg::OP_CANCEL, 16'hABCD, 32'h0000_0000);
    issue_request(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    issue_request(dtq_pkg::OP_INSERT, 16'h0007, 32'h0000_0005);
    issue_request(dtq_pkg::OP_INSERT, 16'h0007, 32'h0000_0003);
    issue_request(dtq_pkg::OP_INSERT, 16'h0009, 32'h0000_0004);
    issue_request(dtq_pkg::OP_CANCEL, 16'h0007, 32'h0000_0000);
    issue_request(dtq_pkg::OP_TICK, 16'h0000, 32'h0000_0000);
    issue_request(dtq_pkg::OP_CANCEL, 16'h0009, 32'h0000_0000);
    issue_request(dtq_pkg::OP_INSERT, 16'h0005, 32'h0000_0004);
    repeat (4) issue_request(dtq_pkg::OP_TICK, 16'h0000, 32'h0000_0000);
    issue_request(dtq_pkg::OP_CANCEL, 16'hFFFF, 32'h0000_0000);
    issue_request(dtq_pkg::OP_CANCEL, 16'h0000, 32'h0000_0000);
    issue_request(dtq_pkg::OP_INSERT, 16'h5555, 32'hAAAA_AAAA);
    issue_request(dtq_pkg::OP_CANCEL, 16'h5555, 32'h0000_0000);
  endtask

  task automatic test_full_table();
    int k;
    steady_flow     = 1'b1;
    rsp_hold_cycles = 300;
    for (k = 0; k < dtq_pkg::DEPTH + 2; k++) begin
      issue_request(dtq_pkg::OP_INSERT, any_tid(), $urandom_range(1, 6));
    end
    steady_flow = 1'b0;
    while (sleeper_count > 0) begin
      issue_request(dtq_pkg::OP_TICK, any_tid(), $urandom);
    end
  endtask

  task automatic test_mixed_traffic(input int count);
    int k;
    int r;
    int s;
    logic [dtq_pkg::TID_W-1:0]  tid;
    logic [dtq_pkg::TIME_W-1:0] wait_ticks;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        tid = $urandom_range(0, 1) ? dtq_pkg::TID_W'($urandom_range(0, 7)) : any_tid();
        s   = $urandom_range(0, 99);
        if (s < 4) begin
          wait_ticks = '0;
        end else if (s < 82) begin
          wait_ticks = $urandom_range(1, 12);
        end else if (s < 95) begin
          wait_ticks = $urandom_range(13, 1000);
        end else begin
          wait_ticks = $urandom;
        end
        issue_request(dtq_pkg::OP_INSERT, tid, wait_ticks);
      end else if (r < 75) begin
        issue_request(dtq_pkg::OP_TICK, any_tid(), $urandom);
      end else if (r < 96) begin
        if (sleeper_count > 0 && $urandom_range(0, 3) != 0) begin
          tid = sleeper_id[slot($urandom_range(0, sleeper_count - 1))];
        end else begin
          tid = any_tid();
        end
        issue_request(dtq_pkg::OP_CANCEL, tid, $urandom);
      end else begin
        issue_request(OP_UNUSED, any_tid(), $urandom);
      end
    end
  endtask

  initial begin : receiver
    int stall;
    stall     = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp.ready = 1'b0;
        rsp_hold_cycles--;
      end else if (stall > 0) begin
        rsp.ready = 1'b0;
        stall--;
      end else begin
        rsp.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d, thread_id_res %0h", rsp.kind, rsp.thread_id_res);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (rsp.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, rsp.kind);
          error_count++;
        end
        if (rsp.thread_id_res !== want.tid) begin
          $error("thread_id_res: expected %0h, actual %0h", want.tid, rsp.thread_id_res);
          error_count++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, rsp.last);
          error_count++;
        end
        if (rsp.occupancy !== want.occ) begin
          $error("occupancy: expected %0d, actual %0d", want.occ, rsp.occupancy);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("[delta_timer_queue] ERROR");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    error_count     = 0;
    sleeper_count   = 0;
    steady_flow     = 1'b0;
    rsp_hold_cycles = 0;
    req.valid       = 1'b0;
    req.operation   = dtq_pkg::OP_INSERT;
    req.thread_id   = '0;
    req.wait_time   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_list_edges();
    test_full_table();
    test_mixed_traffic(28);
    steady_flow = 1'b1;
    test_mixed_traffic(28);
    steady_flow = 1'b0;
    test_mixed_traffic(28);
    steady_flow = 1'b1;
    test_mixed_traffic(28);
    steady_flow = 1'b0;

    @(negedge clk);
    req.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[delta_timer_queue] OK");
    end else begin
      $display("[delta_timer_queue] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/dtq_pkg.sv
rtl/core/dtq_in_if.sv
rtl/core/dtq_out_if.sv
rtl/core/delta_timer_queue.sv
rtl/core/dtq_checker.sv
test/tb_top.sv
